@@ rtl/iafd_pkg.sv @@
// Shared types and constants of the IMU angle frame decoder.
package iafd_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_DEG   = 2'd2;

  // Register reset values
  localparam logic [7:0] HEADER_BYTE_RST = 8'h55;
  localparam logic [7:0] FRAME_TYPE_RST  = 8'h53;
  localparam logic       SCALE_DEG_RST   = 1'b1;

  // Byte counter: 0 while hunting, 2 right after lock, 10 when the checksum byte is due
  localparam int unsigned CNT_W = 4;
  localparam logic [CNT_W-1:0] CNT_HUNT = 4'd0;
  localparam logic [CNT_W-1:0] CNT_LOCK = 4'd2;
  localparam logic [CNT_W-1:0] CNT_CSUM = 4'd10;

  // Payload bytes 2..9 of a frame
  localparam int unsigned PAYLOAD_BYTES = 8;

  // Degree scaling: raw * 180 >>> 8
  localparam int unsigned PROD_W = 25;
  localparam logic signed [PROD_W-1:0] DEG_MULT = 25'sd180;

  // Queue depths
  localparam int unsigned MID_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  // Completed frame, front to back
  typedef struct packed {
    logic                             ok;
    logic                             scale;
    logic [PAYLOAD_BYTES-1:0][7:0]    payload;
  } frame_rec_t;

  // One result item
  typedef struct packed {
    logic        checksum_ok;
    logic [15:0] axis_x;
    logic [15:0] axis_y;
    logic [15:0] axis_z;
    logic [15:0] temperature;
  } result_t;

endpackage

@@ rtl/iafd_fifo.sv @@
// Small synchronous queue used between the decoder stages.
module iafd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Write entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/iafd_front.sv @@
// Front end: configuration registers, sync hunt, byte counting and checksum.
module iafd_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [iafd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_wdata,
  input  logic                               byte_valid,
  input  logic [7:0]                         rx_byte,
  output logic                               rec_push,
  output iafd_pkg::frame_rec_t               rec
);

  logic [7:0]                    header_byte_r;
  logic [7:0]                    frame_type_r;
  logic                          scale_deg_r;
  logic [iafd_pkg::CNT_W-1:0]    byte_count_r, byte_count_nxt;
  logic [7:0]                    prev_byte_r, prev_byte_nxt;
  logic [7:0]                    run_sum_r, run_sum_nxt;
  logic [iafd_pkg::PAYLOAD_BYTES-1:0][7:0] frame_store_r;
  logic                          hunting, collecting, at_csum;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_byte_r <= iafd_pkg::HEADER_BYTE_RST;
      frame_type_r  <= iafd_pkg::FRAME_TYPE_RST;
      scale_deg_r   <= iafd_pkg::SCALE_DEG_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        iafd_pkg::REG_HEADER_BYTE: header_byte_r <= cfg_wdata;
        iafd_pkg::REG_FRAME_TYPE:  frame_type_r  <= cfg_wdata;
        iafd_pkg::REG_SCALE_DEG:   scale_deg_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Classify the incoming item by where the frame stands
  assign hunting    = (byte_count_r < iafd_pkg::CNT_LOCK) || (byte_count_r > iafd_pkg::CNT_CSUM);
  assign collecting = !hunting && (byte_count_r < iafd_pkg::CNT_CSUM);
  assign at_csum    = (byte_count_r == iafd_pkg::CNT_CSUM);

  always_comb begin
    byte_count_nxt = byte_count_r;
    prev_byte_nxt  = prev_byte_r;
    run_sum_nxt    = run_sum_r;
    if (byte_valid) begin
      if (hunting) begin
        byte_count_nxt = iafd_pkg::CNT_HUNT;
        if (prev_byte_r == header_byte_r && rx_byte == frame_type_r) begin
          byte_count_nxt = iafd_pkg::CNT_LOCK;
          run_sum_nxt    = header_byte_r + frame_type_r;
        end
        prev_byte_nxt = rx_byte;
      end else if (collecting) begin
        run_sum_nxt    = run_sum_r + rx_byte;
        byte_count_nxt = byte_count_r + 1'b1;
      end else begin
        byte_count_nxt = iafd_pkg::CNT_HUNT;
        prev_byte_nxt  = 8'd0;
        run_sum_nxt    = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= iafd_pkg::CNT_HUNT;
      prev_byte_r  <= 8'd0;
      run_sum_r    <= 8'd0;
    end else begin
      byte_count_r <= byte_count_nxt;
      prev_byte_r  <= prev_byte_nxt;
      run_sum_r    <= run_sum_nxt;
    end
  end

  // Shift payload bytes in; entry 0 ends up holding frame byte 2
  always_ff @(posedge clk) begin
    if (byte_valid && collecting) begin
      frame_store_r <= {rx_byte, frame_store_r[iafd_pkg::PAYLOAD_BYTES-1:1]};
    end
  end

  // Hand the finished frame to the back end on the checksum byte
  assign rec_push    = byte_valid && at_csum;
  assign rec.ok      = (run_sum_r == rx_byte);
  assign rec.scale   = scale_deg_r;
  assign rec.payload = frame_store_r;

endmodule

@@ rtl/iafd_back.sv @@
// Back end: unpack axis and temperature values, scale, hold last good values.
module iafd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rec_empty,
  input  iafd_pkg::frame_rec_t  rec,
  output logic                  rec_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output iafd_pkg::result_t     res
);

  logic signed [15:0]                  raw_x, raw_y, raw_z;
  logic signed [iafd_pkg::PROD_W-1:0]  prod_x, prod_y, prod_z;
  logic [15:0]                         new_x, new_y, new_z, new_t;
  logic [15:0]                         last_x_r, last_y_r, last_z_r, last_t_r;
  logic                                take;

  assign take     = !rec_empty && !res_full;
  assign rec_pop  = take;
  assign res_push = take;

  // Unpack little-endian values
  assign raw_x = $signed({rec.payload[1], rec.payload[0]});
  assign raw_y = $signed({rec.payload[3], rec.payload[2]});
  assign raw_z = $signed({rec.payload[5], rec.payload[4]});
  assign new_t = {rec.payload[7], rec.payload[6]};

  // Scale to 1/128 degree: floor(raw * 180 / 256)
  assign prod_x = iafd_pkg::PROD_W'(raw_x) * iafd_pkg::DEG_MULT;
  assign prod_y = iafd_pkg::PROD_W'(raw_y) * iafd_pkg::DEG_MULT;
  assign prod_z = iafd_pkg::PROD_W'(raw_z) * iafd_pkg::DEG_MULT;

  assign new_x = rec.scale ? prod_x[23:8] : raw_x;
  assign new_y = rec.scale ? prod_y[23:8] : raw_y;
  assign new_z = rec.scale ? prod_z[23:8] : raw_z;

  // Hold the last good values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r <= 16'd0;
      last_y_r <= 16'd0;
      last_z_r <= 16'd0;
      last_t_r <= 16'd0;
    end else if (take && rec.ok) begin
      last_x_r <= new_x;
      last_y_r <= new_y;
      last_z_r <= new_z;
      last_t_r <= new_t;
    end
  end

  // Fresh values on a good frame, repeat the held ones on a bad frame
  assign res.checksum_ok = rec.ok;
  assign res.axis_x      = rec.ok ? new_x : last_x_r;
  assign res.axis_y      = rec.ok ? new_y : last_y_r;
  assign res.axis_z      = rec.ok ? new_z : last_z_r;
  assign res.temperature = rec.ok ? new_t : last_t_r;

endmodule

@@ rtl/imu_angle_frame_decoder.sv @@
// Top level of the IMU angle frame decoder: front end, frame queue, back end, result queue.
//
//   channel   | ports                                   | accepted when
//   ----------+-----------------------------------------+---------------------
//   input     | push, full, in_rx_byte                  | push && !full
//   result    | empty, pop, out_checksum_ok, out_axis_* | pop && !empty
//             | out_temperature                         |
//   config    | cfg_we, cfg_index, cfg_wdata            | cfg_we
//
// One byte per cycle is taken if !full; the front end handles each in its arrival cycle.
// A frame is queued on its checksum byte and enters the result queue when it has room.
// full rises only while the frame queue is full, i.e. the result queue is backed up.
// Synchronous reset clears all control state directly; no clearing pass.
module imu_angle_frame_decoder #(
  parameter int unsigned MID_DEPTH = iafd_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = iafd_pkg::OUT_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [iafd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                       cfg_wdata,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       in_rx_byte,
  output logic                             empty,
  input  logic                             pop,
  output logic                             out_checksum_ok,
  output logic signed [15:0]               out_axis_x,
  output logic signed [15:0]               out_axis_y,
  output logic signed [15:0]               out_axis_z,
  output logic signed [15:0]               out_temperature
);

  logic                  byte_valid;
  logic                  rec_push, rec_pop, rec_full, rec_empty;
  iafd_pkg::frame_rec_t  rec_in, rec_out;
  logic                  res_push, res_full;
  iafd_pkg::result_t     res_in, res_out;

  // Stall input while no room is left for a finished frame
  assign full       = rec_full;
  assign byte_valid = push && !rec_full;

  iafd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (byte_valid),
    .rx_byte    (in_rx_byte),
    .rec_push   (rec_push),
    .rec        (rec_in)
  );

  iafd_fifo #(
    .WIDTH ($bits(iafd_pkg::frame_rec_t)),
    .DEPTH (MID_DEPTH)
  ) u_frame_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rec_push),
    .wdata (rec_in),
    .full  (rec_full),
    .pop   (rec_pop),
    .rdata (rec_out),
    .empty (rec_empty)
  );

  iafd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_empty (rec_empty),
    .rec       (rec_out),
    .rec_pop   (rec_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  iafd_fifo #(
    .WIDTH ($bits(iafd_pkg::result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_checksum_ok = res_out.checksum_ok;
  assign out_axis_x      = res_out.axis_x;
  assign out_axis_y      = res_out.axis_y;
  assign out_axis_z      = res_out.axis_z;
  assign out_temperature = res_out.temperature;

endmodule

@@ rtl/iafd_checker.sv @@
// Port-level checks of the IMU angle frame decoder, bound to the top level.
module iafd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           push,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic                           out_checksum_ok,
  input logic signed [15:0]             out_axis_x,
  input logic signed [15:0]             out_axis_y,
  input logic signed [15:0]             out_axis_z,
  input logic signed [15:0]             out_temperature
);

  // Come out of reset with nothing queued and room for input
  a_reset_clear: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (empty && !full))
    else $error("queues not clear after reset");

  // Hold a waiting result until it is taken
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> ($stable(out_checksum_ok) && $stable(out_axis_x) &&
                          $stable(out_axis_y) && $stable(out_axis_z) &&
                          $stable(out_temperature)))
    else $error("waiting result changed");

  // A result appearing from empty follows an accepted item, registered in both queues
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(empty) |-> $past(push && !full, 2))
    else $error("result appeared without an input item");

  // A bad frame repeats the values of the result before it
  a_bad_repeats: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop) ##1 (!empty && !out_checksum_ok) |->
      (out_axis_x == $past(out_axis_x) && out_axis_y == $past(out_axis_y) &&
       out_axis_z == $past(out_axis_z) && out_temperature == $past(out_temperature)))
    else $error("bad frame did not repeat last good values");

endmodule

bind imu_angle_frame_decoder iafd_checker u_iafd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .push            (push),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .out_checksum_ok (out_checksum_ok),
  .out_axis_x      (out_axis_x),
  .out_axis_y      (out_axis_y),
  .out_axis_z      (out_axis_z),
  .out_temperature (out_temperature)
);
